// ===== design/cdt_pkg.sv =====
// Package for the mm:ss countdown timer: phase, input and sound codes,
// the digit and state records, and the result record.
// No dependencies.
package cdt_pkg;

    localparam int TicksWidth = 16;
    localparam logic [TicksWidth-1:0] TicksPerSecondReset = 16'd60;

    localparam logic [3:0] MinTop    = 4'd9;   // both minute digits
    localparam logic [3:0] SecOneTop = 4'd9;
    localparam logic [2:0] SecTenTop = 3'd5;

    typedef enum logic [2:0] {
        PH_SETTING      = 3'd0,
        PH_COUNTING     = 3'd1,
        PH_PAUSED       = 3'd2,
        PH_ALARM        = 3'd3,
        PH_ALARM_PAUSED = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_TOUCH  = 2'd1,
        MODE_REPEAT = 2'd2
    } mode_t;

    localparam logic [3:0] BT_START     = 4'd0;
    localparam logic [3:0] BT_STOP      = 4'd1;
    localparam logic [3:0] BT_RESET     = 4'd2;
    localparam logic [3:0] BT_MIN10_UP  = 4'd3;
    localparam logic [3:0] BT_MIN1_UP   = 4'd4;
    localparam logic [3:0] BT_MIN10_DN  = 4'd5;
    localparam logic [3:0] BT_MIN1_DN   = 4'd6;
    localparam logic [3:0] BT_SEC10_UP  = 4'd7;
    localparam logic [3:0] BT_SEC1_UP   = 4'd8;
    localparam logic [3:0] BT_SEC10_DN  = 4'd9;
    localparam logic [3:0] BT_SEC1_DN   = 4'd10;

    localparam logic [1:0] SND_NONE    = 2'd0;
    localparam logic [1:0] SND_ACCEPT  = 2'd1;
    localparam logic [1:0] SND_REFUSE  = 2'd2;

    typedef struct packed {
        logic [3:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
    } digits_t;

    typedef struct packed {
        logic [2:0]            phase;
        digits_t               digits;
        logic [TicksWidth-1:0] subsec;
    } timer_t;

    typedef struct packed {
        logic [2:0] timer_state;
        digits_t    digits;
        logic [1:0] sound;
        logic       start_enabled;
        logic       stop_enabled;
    } result_t;

endpackage

// ===== design/cdt_if.sv =====
// Handshake channels of the countdown timer: button/tick requests,
// results and the configuration write. Depends on cdt_pkg.
interface cdt_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] button;

    modport source (output valid, output mode, output button, input ready);
    modport sink   (input valid, input mode, input button, output ready);
endinterface

interface cdt_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] timer_state;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    logic [1:0] sound;
    logic       start_enabled;
    logic       stop_enabled;

    modport source (output valid, output timer_state, output minute_tens,
                    output minute_ones, output second_tens, output second_ones,
                    output sound, output start_enabled, output stop_enabled,
                    input ready);
    modport sink   (input valid, input timer_state, input minute_tens,
                    input minute_ones, input second_tens, input second_ones,
                    input sound, input start_enabled, input stop_enabled,
                    output ready);
endinterface

interface cdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cdt_core.sv =====
// Next-state and result logic of the countdown timer for one request.
// Depends on cdt_pkg.
module cdt_core
    import cdt_pkg::*;
(
    input  timer_t                cur,
    input  logic [1:0]            mode,
    input  logic [3:0]            button,
    input  logic [TicksWidth-1:0] ticks_per_second,
    output timer_t                nxt,
    output result_t               res
);

    function automatic logic [3:0] step_up(input logic [3:0] d, input logic [3:0] top);
        return (d >= top) ? 4'd0 : d + 4'd1;
    endfunction

    function automatic logic [3:0] step_down(input logic [3:0] d, input logic [3:0] top);
        return (d == 4'd0 || d > top) ? top : d - 4'd1;
    endfunction

    function automatic digits_t edit(input digits_t d, input logic [3:0] b);
        digits_t r;
        r = d;
        case (b)
            BT_MIN10_UP: r.min_tens = step_up(d.min_tens, MinTop);
            BT_MIN1_UP:  r.min_ones = step_up(d.min_ones, MinTop);
            BT_MIN10_DN: r.min_tens = step_down(d.min_tens, MinTop);
            BT_MIN1_DN:  r.min_ones = step_down(d.min_ones, MinTop);
            BT_SEC10_UP: r.sec_tens = 3'(step_up({1'b0, d.sec_tens}, {1'b0, SecTenTop}));
            BT_SEC1_UP:  r.sec_ones = step_up(d.sec_ones, SecOneTop);
            BT_SEC10_DN: r.sec_tens = 3'(step_down({1'b0, d.sec_tens}, {1'b0, SecTenTop}));
            BT_SEC1_DN:  r.sec_ones = step_down(d.sec_ones, SecOneTop);
            default:     r = d;
        endcase
        return r;
    endfunction

    // borrow chain seconds -> minutes; total is known nonzero here
    function automatic digits_t dec_second(input digits_t d);
        digits_t r;
        r = d;
        if (d.sec_ones != 4'd0) begin
            r.sec_ones = d.sec_ones - 4'd1;
        end
        else begin
            r.sec_ones = SecOneTop;
            if (d.sec_tens != 3'd0) begin
                r.sec_tens = d.sec_tens - 3'd1;
            end
            else begin
                r.sec_tens = SecTenTop;
                if (d.min_ones != 4'd0) begin
                    r.min_ones = d.min_ones - 4'd1;
                end
                else begin
                    r.min_ones = MinTop;
                    if (d.min_tens != 4'd0) begin
                        r.min_tens = d.min_tens - 4'd1;
                    end
                    else begin
                        r = '0;
                    end
                end
            end
        end
        return r;
    endfunction

    logic                  cur_zero;
    logic [TicksWidth:0]   subsec_inc;
    digits_t               dec_digits;
    logic [1:0]            sound;

    assign cur_zero   = (cur.digits == '0);
    assign subsec_inc = {1'b0, cur.subsec} + {{TicksWidth{1'b0}}, 1'b1};
    assign dec_digits = dec_second(cur.digits);

    always_comb
    begin
        nxt   = cur;
        sound = SND_NONE;
        case (mode)
            MODE_TICK:
            begin
                if (cur.phase == PH_COUNTING) begin
                    if (cur_zero) begin
                        nxt.subsec = '0;
                        nxt.phase  = PH_ALARM;
                    end
                    else if (subsec_inc >= {1'b0, ticks_per_second}) begin
                        nxt.subsec = '0;
                        nxt.digits = dec_digits;
                        if (dec_digits == '0) begin
                            nxt.phase = PH_ALARM;
                        end
                    end
                    else begin
                        nxt.subsec = subsec_inc[TicksWidth-1:0];
                    end
                end
            end
            MODE_TOUCH:
            begin
                if (button == BT_RESET) begin
                    sound      = SND_ACCEPT;
                    nxt.digits = '0;
                    nxt.phase  = PH_SETTING;
                end
                else if (button == BT_START) begin
                    case (cur.phase)
                        PH_SETTING:
                        begin
                            sound = SND_ACCEPT;
                            if (!cur_zero) begin
                                nxt.subsec = '0;
                                nxt.phase  = PH_COUNTING;
                            end
                        end
                        PH_PAUSED:
                        begin
                            sound     = SND_ACCEPT;
                            nxt.phase = PH_COUNTING;
                        end
                        PH_ALARM_PAUSED:
                        begin
                            sound     = SND_ACCEPT;
                            nxt.phase = PH_ALARM;
                        end
                        default: sound = SND_REFUSE;
                    endcase
                end
                else if (button == BT_STOP) begin
                    case (cur.phase)
                        PH_COUNTING:
                        begin
                            sound     = SND_ACCEPT;
                            nxt.phase = PH_PAUSED;
                        end
                        PH_ALARM:
                        begin
                            sound     = SND_ACCEPT;
                            nxt.phase = PH_ALARM_PAUSED;
                        end
                        default: sound = SND_REFUSE;
                    endcase
                end
                else if (cur.phase == PH_SETTING) begin
                    nxt.digits = edit(cur.digits, button);
                end
            end
            MODE_REPEAT:
            begin
                if (cur.phase == PH_SETTING) begin
                    nxt.digits = edit(cur.digits, button);
                end
            end
            default: nxt = cur;
        endcase
    end

    always_comb
    begin
        res.timer_state   = nxt.phase;
        res.digits        = nxt.digits;
        res.sound         = sound;
        res.start_enabled = (nxt.phase == PH_SETTING) || (nxt.phase == PH_PAUSED)
                            || (nxt.phase == PH_ALARM_PAUSED);
        res.stop_enabled  = !res.start_enabled;
    end

endmodule

// ===== design/countdown_timer_mmss.sv =====
// Top level of the mm:ss countdown kitchen timer: request register,
// timer state, result register and the tick-rate register.
// Depends on cdt_pkg, cdt_if and cdt_core.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------
//  cmd     | in  | valid/ready  | mode, button
//  res     | out | valid/ready  | timer_state, four digits, sound, enables
//  cfg     | in  | valid/ready  | data = ticks_per_second
//
// One request per cycle sustained while results are taken. A request waits
// in the request register; the timer logic then updates the state and
// loads the result register as the request leaves, and the result is then
// offered. A stalled result holds the result register and the timer
// state; the request register still takes a new request while it is empty
// or the result slot is free or draining, so the input stalls only when
// both registers are full.
// Reset clears the phase, digits and sub-second count and loads 60 ticks
// per second; cfg is always ready.
module countdown_timer_mmss
    import cdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cdt_cmd_if.sink   cmd,
    cdt_res_if.source res,
    cdt_cfg_if.sink   cfg
);

    logic                  cmd_valid_reg;
    logic [1:0]            mode_reg;
    logic [3:0]            button_reg;
    logic                  res_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    timer_t                timer_reg;
    timer_t                timer_next;
    logic [TicksWidth-1:0] tps_reg;
    logic                  advance;

    // the pipeline moves when the result slot is empty or being taken
    assign advance   = !res_valid_reg || res.ready;
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tps_reg <= TicksPerSecondReset;
        end
        else if (cfg.valid) begin
            tps_reg <= cfg.data;
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready) begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid) begin
            mode_reg   <= cmd.mode;
            button_reg <= cmd.button;
        end
    end

    cdt_core u_core (
        .cur              (timer_reg),
        .mode             (mode_reg),
        .button           (button_reg),
        .ticks_per_second (tps_reg),
        .nxt              (timer_next),
        .res              (result_next)
    );

    // timer state commits only when a request leaves the request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timer_reg     <= '{phase: PH_SETTING, digits: '0, subsec: '0};
            res_valid_reg <= 1'b0;
        end
        else if (advance) begin
            res_valid_reg <= cmd_valid_reg;
            if (cmd_valid_reg) begin
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cmd_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.timer_state   = result_reg.timer_state;
    assign res.minute_tens   = result_reg.digits.min_tens;
    assign res.minute_ones   = result_reg.digits.min_ones;
    assign res.second_tens   = result_reg.digits.sec_tens;
    assign res.second_ones   = result_reg.digits.sec_ones;
    assign res.sound         = result_reg.sound;
    assign res.start_enabled = result_reg.start_enabled;
    assign res.stop_enabled  = result_reg.stop_enabled;

endmodule

// ===== dv/timer_display_checker.sv =====
// Checker for the mm:ss countdown timer: tracks timer state from accepted
// requests and config writes, and compares every result field by field.
// Depends on cdt_pkg and cdt_if.
module timer_display_checker
    import cdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cdt_cmd_if   cmd,
    cdt_res_if   res,
    cdt_cfg_if   cfg,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TicksWidth-1:0] tick_rate;
    phase_t                phase_q;
    digits_t               shown;
    logic [TicksWidth-1:0] subsec;

    result_t display_q[$];
    result_t want;
    int      err_cnt;

    function automatic logic [3:0] wrap_inc(logic [3:0] d, logic [3:0] top);
        return (d >= top) ? 4'd0 : d + 4'd1;
    endfunction

    function automatic logic [3:0] wrap_dec(logic [3:0] d, logic [3:0] top);
        return (d == 4'd0 || d > top) ? top : d - 4'd1;
    endfunction

    // Borrow chain: ss ones, ss tens, mm ones, mm tens.
    function automatic void take_second();
        if (shown.sec_ones != 4'd0)
            shown.sec_ones = shown.sec_ones - 4'd1;
        else if (shown.sec_tens != 3'd0)
        begin
            shown.sec_ones = SecOneTop;
            shown.sec_tens = shown.sec_tens - 3'd1;
        end
        else if (shown.min_ones != 4'd0)
        begin
            shown.sec_ones = SecOneTop;
            shown.sec_tens = SecTenTop;
            shown.min_ones = shown.min_ones - 4'd1;
        end
        else if (shown.min_tens != 4'd0)
        begin
            shown.sec_ones = SecOneTop;
            shown.sec_tens = SecTenTop;
            shown.min_ones = MinTop;
            shown.min_tens = shown.min_tens - 4'd1;
        end
        else
            shown = '0;
    endfunction

    function automatic void count_tick();
        logic [TicksWidth:0] nxt;
        if (shown == '0)
        begin
            subsec  = '0;
            phase_q = PH_ALARM;
        end
        else
        begin
            nxt = {1'b0, subsec} + 1'b1;
            // a rate of zero passes this test on every tick
            if (nxt >= {1'b0, tick_rate})
            begin
                subsec = '0;
                take_second();
                if (shown == '0)
                    phase_q = PH_ALARM;
            end
            else
                subsec = nxt[TicksWidth-1:0];
        end
    endfunction

    function automatic void step_digit(logic [3:0] b);
        case (b)
            BT_MIN10_UP: shown.min_tens = wrap_inc(shown.min_tens, MinTop);
            BT_MIN1_UP:  shown.min_ones = wrap_inc(shown.min_ones, MinTop);
            BT_MIN10_DN: shown.min_tens = wrap_dec(shown.min_tens, MinTop);
            BT_MIN1_DN:  shown.min_ones = wrap_dec(shown.min_ones, MinTop);
            BT_SEC10_UP: shown.sec_tens = 3'(wrap_inc({1'b0, shown.sec_tens}, {1'b0, SecTenTop}));
            BT_SEC1_UP:  shown.sec_ones = wrap_inc(shown.sec_ones, SecOneTop);
            BT_SEC10_DN: shown.sec_tens = 3'(wrap_dec({1'b0, shown.sec_tens}, {1'b0, SecTenTop}));
            BT_SEC1_DN:  shown.sec_ones = wrap_dec(shown.sec_ones, SecOneTop);
            default: ;
        endcase
    endfunction

    function automatic result_t predict_display(logic [1:0] m, logic [3:0] b);
        result_t    r;
        logic [1:0] snd;
        snd = SND_NONE;
        if (m == MODE_TICK)
        begin
            if (phase_q == PH_COUNTING)
                count_tick();
        end
        else if (m == MODE_TOUCH && b <= BT_RESET)
        begin
            if (b == BT_RESET)
            begin
                snd     = SND_ACCEPT;
                shown   = '0;
                phase_q = PH_SETTING;
            end
            else if (phase_q == PH_SETTING)
            begin
                if (b == BT_START)
                begin
                    snd = SND_ACCEPT;
                    if (shown != '0)
                    begin
                        subsec  = '0;
                        phase_q = PH_COUNTING;
                    end
                end
                else
                    snd = SND_REFUSE;
            end
            else if (b == BT_START)
            begin
                case (phase_q)
                    PH_PAUSED:
                    begin
                        snd     = SND_ACCEPT;
                        phase_q = PH_COUNTING;
                    end
                    PH_ALARM_PAUSED:
                    begin
                        snd     = SND_ACCEPT;
                        phase_q = PH_ALARM;
                    end
                    default: snd = SND_REFUSE;
                endcase
            end
            else
            begin
                case (phase_q)
                    PH_COUNTING:
                    begin
                        snd     = SND_ACCEPT;
                        phase_q = PH_PAUSED;
                    end
                    PH_ALARM:
                    begin
                        snd     = SND_ACCEPT;
                        phase_q = PH_ALARM_PAUSED;
                    end
                    default: snd = SND_REFUSE;
                endcase
            end
        end
        else if ((m == MODE_TOUCH || m == MODE_REPEAT) && phase_q == PH_SETTING)
            step_digit(b);

        r.timer_state   = phase_q;
        r.digits        = shown;
        r.sound         = snd;
        r.start_enabled = (phase_q == PH_SETTING || phase_q == PH_PAUSED ||
                           phase_q == PH_ALARM_PAUSED);
        r.stop_enabled  = !r.start_enabled;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate = TicksPerSecondReset;
            phase_q   = PH_SETTING;
            shown     = '0;
            subsec    = '0;
            err_cnt   = 0;
            display_q.delete();
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (display_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result with no request pending, expected none, %s",
                             $time, "actual");
                    $display("    state %0d digits %0d%0d:%0d%0d",
                             res.timer_state, res.minute_tens, res.minute_ones,
                             res.second_tens, res.second_ones);
                end
                else
                begin
                    want = display_q.pop_front();
                    check_field("timer_state", want.timer_state, res.timer_state);
                    check_field("minute_tens", want.digits.min_tens, res.minute_tens);
                    check_field("minute_ones", want.digits.min_ones, res.minute_ones);
                    check_field("second_tens", want.digits.sec_tens, res.second_tens);
                    check_field("second_ones", want.digits.sec_ones, res.second_ones);
                    check_field("sound", want.sound, res.sound);
                    check_field("start_enabled", want.start_enabled, res.start_enabled);
                    check_field("stop_enabled", want.stop_enabled, res.stop_enabled);
                end
            end
            if (cfg.valid && cfg.ready)
                tick_rate = cfg.data;
            if (cmd.valid && cmd.ready)
                display_q.push_back(predict_display(cmd.mode, cmd.button));
            outstanding <= display_q.size();
            errors      <= err_cnt;
        end
    end

endmodule

// ===== dv/tb_countdown_timer_mmss.sv =====
// Testbench top for the mm:ss countdown timer: clock, reset, request and
// config stimulus, result back-pressure and the verdict.
// Depends on cdt_pkg, cdt_if, countdown_timer_mmss and timer_display_checker.
module tb_countdown_timer_mmss
    import cdt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Longest legal quiet stretch is the forced result hold (HoldCycles)
    // plus a little; the limit sits well above it.
    localparam int HoldCycles = 300;
    localparam int StallLimit = 3000;

    logic clk;
    logic rst_n;

    cdt_cmd_if cmd_ch();
    cdt_res_if res_ch();
    cdt_cfg_if cfg_ch();

    int fail_count;
    int outstanding;
    int sent;
    int rate;          // ticks per second currently programmed
    int idle_cycles;
    bit no_idle;       // both sides run without gaps while set
    bit hold_results;  // asks the result side for one long hold

    countdown_timer_mmss dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    timer_display_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg         (cfg_ch),
        .errors      (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int draw_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [1:0] edit_mode();
        return $urandom_range(0, 1) ? MODE_REPEAT : MODE_TOUCH;
    endfunction

    // Result side: random stalls, plus one long hold on request so the
    // block backs up and has to stall its request input.
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                res_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                stall = draw_gap();
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: any accepted request, result or config write restarts it.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // One request; valid stays up across back-to-back requests.
    task automatic push_request(input logic [1:0] m, input logic [3:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.mode   <= m;
        cmd_ch.button <= b;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        sent++;
    endtask

    // Drain: every expected result in, then a margin of idle clocks. The
    // checker's count is registered, hence the first wait.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [15:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        rate = value;
    endtask

    // One kitchen-timer use: clear, dial a time (usually a few seconds so
    // the alarm is reached), start, then mostly ticks with stop/start
    // presses, the odd reset and some junk mixed in.
    task automatic play_episode();
        int n_ticks;
        int roll;
        push_request(MODE_TOUCH, BT_RESET);
        if ($urandom_range(0, 3) != 0)
        begin
            repeat ($urandom_range(1, 4)) push_request(edit_mode(), BT_SEC1_UP);
            if ($urandom_range(0, 3) == 0)
                push_request(edit_mode(), BT_SEC10_UP);
        end
        else
        begin
            // any digit, down-steps wrap to large times and exercise borrows
            repeat ($urandom_range(1, 8))
                push_request(edit_mode(), 4'($urandom_range(BT_MIN10_UP, BT_SEC1_DN)));
        end
        push_request(MODE_TOUCH, BT_START);
        n_ticks = $urandom_range(0, 6 * rate + 12);
        repeat (n_ticks)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
                push_request(MODE_TICK, 4'($urandom()));
            else if (roll < 85)
                push_request(MODE_TOUCH, $urandom_range(0, 1) ? BT_STOP : BT_START);
            else if (roll < 87)
                push_request(MODE_TOUCH, BT_RESET);
            else
                push_request(2'($urandom()), 4'($urandom()));
        end
    endtask

    task automatic random_session(input int target, input bit with_hold);
        int first;
        bit held;
        first = sent;
        held  = 1'b0;
        while (sent - first < target)
        begin
            if (with_hold && !held && sent - first >= 40)
            begin
                hold_results = 1'b1;
                held         = 1'b1;
            end
            play_episode();
        end
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.mode   <= MODE_TICK;
        cmd_ch.button <= BT_START;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        sent          = 0;
        rate          = TicksPerSecondReset;
        no_idle       = 1'b0;
        hold_results  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset tick rate.
        // setting: refused stop, start at 00:00, ignored repeats and tick
        push_request(MODE_TOUCH, BT_STOP);
        push_request(MODE_TOUCH, BT_START);
        push_request(MODE_REPEAT, BT_START);
        push_request(MODE_REPEAT, BT_RESET);
        push_request(MODE_TICK, BT_START);
        // every digit wraps down from 0 to its top: 99:59
        push_request(MODE_TOUCH, BT_MIN10_DN);
        push_request(MODE_REPEAT, BT_MIN1_DN);
        push_request(MODE_TOUCH, BT_SEC10_DN);
        push_request(MODE_TOUCH, BT_SEC1_DN);
        // and back up past the top to 00:00, then on to 00:01
        push_request(MODE_REPEAT, BT_MIN10_UP);
        push_request(MODE_TOUCH, BT_MIN1_UP);
        push_request(MODE_TOUCH, BT_SEC10_UP);
        push_request(MODE_REPEAT, BT_SEC1_UP);
        push_request(MODE_TOUCH, BT_SEC1_UP);
        // unused mode and button codes are ignored
        push_request(2'd3, 4'd15);
        push_request(MODE_TOUCH, 4'd11);
        // counting, pause keeps sub-second count, resume, reset
        push_request(MODE_TOUCH, BT_START);
        push_request(MODE_TICK, BT_START);
        push_request(MODE_TICK, 4'd15);
        push_request(MODE_TOUCH, BT_START);
        push_request(MODE_TOUCH, BT_MIN1_UP);
        push_request(MODE_REPEAT, BT_SEC1_UP);
        push_request(MODE_TOUCH, BT_STOP);
        push_request(MODE_TICK, BT_START);
        push_request(MODE_TOUCH, BT_STOP);
        push_request(MODE_TOUCH, BT_START);
        push_request(MODE_TOUCH, BT_RESET);

        // Random phases across tick rates; the first one includes the long
        // result hold.
        write_rate(16'd1);
        random_session(300, 1'b1);
        write_rate(16'd0);      // every tick removes a second
        random_session(200, 1'b0);
        write_rate(16'd3);
        random_session(250, 1'b0);

        // Top rate: the sub-second count climbs without removing a second,
        // then a pause, a refused stop, resume and reset.
        write_rate(16'hFFFF);
        no_idle = 1'b1;
        push_request(MODE_TOUCH, BT_RESET);
        push_request(MODE_TOUCH, BT_SEC1_UP);
        push_request(MODE_TOUCH, BT_START);
        repeat (40) push_request(MODE_TICK, BT_START);
        push_request(MODE_TOUCH, BT_STOP);
        push_request(MODE_TOUCH, BT_STOP);
        push_request(MODE_TOUCH, BT_START);
        push_request(MODE_TOUCH, BT_RESET);

        // Back-to-back stretch with no gaps on either side.
        write_rate(16'd2);
        random_session(150, 1'b0);
        no_idle = 1'b0;
        write_rate(16'd7);
        random_session(150, 1'b0);

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
